### hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam logic [1:0] ACT_REDUCE = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_MUL    = 2'd2;
  localparam logic [1:0] ACT_EQUAL  = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL1,
    CMD_MUL2,
    CMD_SETUP,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_REM_TAKE,
    CMD_Q_START,
    CMD_QP_TAKE,
    CMD_QQ_TAKE,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] action;
    logic       zero_zero;
    logic       mb_zero;
    logic       div_done;
  } stat_t;
endpackage

### hw/rtl/rau_datapath.sv
// Datapath: operand capture, products, Euclid loop and quotient division.
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::ctrl_t      ctrl,
  output rau_pkg::stat_t      stat,
  input  logic [1:0]          action,
  input  logic signed [31:0]  first_num,
  input  logic signed [31:0]  first_den,
  input  logic signed [31:0]  second_num,
  input  logic signed [31:0]  second_den,
  output logic signed [63:0]  out_num,
  output logic signed [63:0]  out_den,
  output logic                is_equal,
  output logic                status
);
  logic [1:0]  act;
  logic [63:0] a, b, c, d;
  logic [63:0] p, q;
  logic [63:0] pr0, pr1;
  logic [63:0] ma, mb;
  logic        na, nb;
  logic [63:0] dividend, divisor, rem, quo;
  logic [6:0]  cnt;
  logic [63:0] qp;

  function automatic logic [63:0] sext(input logic [31:0] raw);
    logic [OPERAND_WIDTH-1:0] v;
    v = raw[OPERAND_WIDTH-1:0];
    return {{(64-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v};
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  logic [63:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[62:0], dividend[63]};
  assign rem_sub = rem_sh - divisor;

  assign stat.action    = act;
  assign stat.zero_zero = (p == 64'd0) && (q == 64'd0);
  assign stat.mb_zero   = (mb == 64'd0);
  assign stat.div_done  = (cnt == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 7'd0;
    end else begin
      case (ctrl.cmd)
        rau_pkg::CMD_LOAD: begin
          act <= action;
          a <= sext(first_num);
          b <= sext(first_den);
          c <= sext(second_num);
          d <= sext(second_den);
        end
        rau_pkg::CMD_MUL1: begin
          // 32x32 products: operands fit in 32 signed bits
          pr0 <= 64'($signed(a[31:0]) * $signed(act == rau_pkg::ACT_MUL ? c[31:0] : d[31:0]));
          pr1 <= 64'($signed(c[31:0]) * $signed(b[31:0]));
          q   <= 64'($signed(b[31:0]) * $signed(d[31:0]));
        end
        rau_pkg::CMD_MUL2: begin
          case (act)
            rau_pkg::ACT_ADD: p <= pr0 + pr1;
            rau_pkg::ACT_MUL: p <= pr0;
            default: begin
              p <= a;
              q <= b;
            end
          endcase
        end
        rau_pkg::CMD_SETUP: begin
          ma <= mag(p);
          mb <= mag(q);
          na <= p[63];
          nb <= q[63];
        end
        rau_pkg::CMD_DIV_START: begin
          dividend <= ma;
          divisor  <= mb;
          rem <= 64'd0;
          cnt <= 7'd64;
        end
        rau_pkg::CMD_DIV_STEP: begin
          dividend <= {dividend[62:0], 1'b0};
          if (!rem_sub[63] || rem_sh[63]) begin
            rem <= rem_sub;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
        end
        rau_pkg::CMD_REM_TAKE: begin
          ma <= mb;
          na <= nb;
          mb <= rem;
          nb <= (rem != 64'd0) && na;
        end
        rau_pkg::CMD_Q_START: begin
          dividend <= mag(p);
          divisor  <= ma;
          rem <= 64'd0;
          cnt <= 7'd64;
        end
        rau_pkg::CMD_QP_TAKE: begin
          qp <= quo;
          dividend <= mag(q);
          rem <= 64'd0;
          cnt <= 7'd64;
        end
        rau_pkg::CMD_QQ_TAKE: begin
          out_num <= (p[63] != na) ? (64'd0 - qp) : qp;
          out_den <= (q[63] != na) ? (64'd0 - quo) : quo;
          is_equal <= 1'b0;
          status <= 1'b0;
        end
        rau_pkg::CMD_FINISH: begin
          // equality or zero over zero
          if (act == rau_pkg::ACT_EQUAL) begin
            out_num <= 64'd0;
            out_den <= 64'd0;
            is_equal <= (a == c) && (b == d);
            status <= 1'b0;
          end else begin
            out_num <= p;
            out_den <= q;
            is_equal <= 1'b0;
            status <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### hw/rtl/rau_ctrl.sv
// Controller state machine sequencing the datapath.
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rau_pkg::stat_t stat,
  output rau_pkg::ctrl_t ctrl
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL1 = 4'd1, S_MUL2 = 4'd2, S_CHK = 4'd3,
                         S_SETUP = 4'd4, S_LOOP = 4'd5, S_DIV = 4'd6, S_QP = 4'd7,
                         S_QQ = 4'd8, S_DONE = 4'd9;
  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    state_next = state;
    ctrl.cmd = rau_pkg::CMD_NONE;
    case (state)
      S_IDLE: if (in_valid && !out_valid) begin
        ctrl.cmd = rau_pkg::CMD_LOAD;
        state_next = S_MUL1;
      end
      S_MUL1: begin ctrl.cmd = rau_pkg::CMD_MUL1; state_next = S_MUL2; end
      S_MUL2: begin ctrl.cmd = rau_pkg::CMD_MUL2; state_next = S_CHK; end
      S_CHK: begin
        if (stat.action == rau_pkg::ACT_EQUAL || stat.zero_zero) begin
          ctrl.cmd = rau_pkg::CMD_FINISH;
          state_next = S_DONE;
        end else begin
          ctrl.cmd = rau_pkg::CMD_SETUP;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.mb_zero) begin
          ctrl.cmd = rau_pkg::CMD_Q_START;
          state_next = S_QP;
        end else begin
          ctrl.cmd = rau_pkg::CMD_DIV_START;
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_REM_TAKE;
          state_next = S_SETUP;
        end else ctrl.cmd = rau_pkg::CMD_DIV_STEP;
      end
      S_QP: begin
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_QP_TAKE;
          state_next = S_QQ;
        end else ctrl.cmd = rau_pkg::CMD_DIV_STEP;
      end
      S_QQ: begin
        if (stat.div_done) begin
          ctrl.cmd = rau_pkg::CMD_QQ_TAKE;
          state_next = S_DONE;
        end else ctrl.cmd = rau_pkg::CMD_DIV_STEP;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall
//  out     | output    | out_valid / out_stall
// Equality and zero over zero finish without division; others run Euclid with
// a 64-step restoring divider per remainder plus two 64-step quotient
// divisions, all on that one shared divider.
// Reset clears controller state. One request at a time; a held result stalls input.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [31:0] first_num,
  input  logic signed [31:0] first_den,
  input  logic signed [31:0] second_num,
  input  logic signed [31:0] second_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_num,
  output logic signed [63:0] out_den,
  output logic               is_equal,
  output logic               status
);
  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .ctrl);

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (.clk, .rst, .ctrl, .stat,
    .action, .first_num, .first_den, .second_num, .second_den,
    .out_num, .out_den, .is_equal, .status);
endmodule

### tb/tb_rational_arithmetic_unit.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
  localparam int OPW = 32;
  localparam int N_RANDOM = 700;
  localparam int WATCHDOG = 60000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } request_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        eq;
    logic        st;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     has_exp;
    answer_t  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic signed [31:0] first_num = '0;
  logic signed [31:0] first_den = '0;
  logic signed [31:0] second_num = '0;
  logic signed [31:0] second_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] out_num;
  logic signed [63:0] out_den;
  logic is_equal;
  logic status;

  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] sext(logic [31:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << OPW) - 64'd1;
    v = {32'd0, raw} & mask;
    if (v[OPW-1]) v = v | ~mask;
    return v;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic answer_t reduce_frac(logic [63:0] p, logic [63:0] q);
    answer_t r;
    logic [63:0] ma, mb, mr;
    logic na, nb, nr;
    r = '0;
    ma = mag(p); mb = mag(q); na = p[63]; nb = q[63];
    if (ma == 0 && mb == 0) begin
      r.num = p; r.den = q; r.st = 1'b1;
      return r;
    end
    while (mb != 0) begin
      mr = ma % mb;
      nr = (mr != 0) && na;
      ma = mb; na = nb;
      mb = mr; nb = nr;
    end
    r.num = (p[63] != na) ? -(mag(p) / ma) : mag(p) / ma;
    r.den = (q[63] != na) ? -(mag(q) / ma) : mag(q) / ma;
    return r;
  endfunction

  function automatic answer_t fraction_result(request_t rq);
    logic [63:0] a, b, c, d;
    answer_t r;
    a = sext(rq.a); b = sext(rq.b); c = sext(rq.c); d = sext(rq.d);
    r = '0;
    case (rq.action)
      rau_pkg::ACT_REDUCE: r = reduce_frac(a, b);
      rau_pkg::ACT_ADD:    r = reduce_frac(a * d + c * b, b * d);
      rau_pkg::ACT_MUL:    r = reduce_frac(a * c, b * d);
      default:             r.eq = (a == c) && (b == d);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'h7fff_ffff - $urandom_range(0, 2);
      3: return 32'd0;
      4: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t mk(logic [1:0] act, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic [31:0] d, logic he,
                              logic [63:0] n, logic [63:0] q, logic e, logic s);
    row_t r;
    r.req = '{act, a, b, c, d};
    r.has_exp = he;
    r.exp = '{n, q, e, s};
    return r;
  endfunction

  row_t directed[$];

  task automatic send(request_t rq);
    @(negedge clk);
    in_valid <= 1'b1;
    action <= rq.action;
    first_num <= rq.a;
    first_den <= rq.b;
    second_num <= rq.c;
    second_den <= rq.d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    request_t rq;
    int burst;
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 5, 0, 0, 0, 1, 1, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 4, 8, 0, 0, 1, 1, 2, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 0, 7, 0, 0, 1, 0, 1, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, -4, 6, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 4, -6, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                          0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_REDUCE, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0,
                          0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_ADD, 1, 2, 1, 3, 1, 5, 6, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(mk(rau_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 0, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0001, 32'hffff_ffff,
                          32'h7fff_ffff, 0, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_MUL, 2, 3, 3, 4, 1, 1, 2, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_MUL, 0, 5, 7, 0, 1, 0, 0, 0, 1));
    directed.push_back(mk(rau_pkg::ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 0,
                          0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_MUL, -3, 7, 5, -2, 0, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_EQUAL, 1, 2, 1, 2, 1, 0, 0, 1, 0));
    directed.push_back(mk(rau_pkg::ACT_EQUAL, 1, 2, 2, 4, 1, 0, 0, 0, 0));
    directed.push_back(mk(rau_pkg::ACT_EQUAL, 32'hffff_ffff, 32'h8000_0000,
                          32'hffff_ffff, 32'h8000_0000, 1, 0, 0, 1, 0));
    directed.push_back(mk(rau_pkg::ACT_EQUAL, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      pending_answers.push_back(directed[i].has_exp ? directed[i].exp
                                                    : fraction_result(directed[i].req));
      send(directed[i].req);
    end
    drop_valid();
    // drain fully before random traffic
    wait (pending_answers.size() == 0);
    // long receiver hold-off while requests keep coming
    long_hold = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 8) long_hold = 1'b0;
      rq.action = 2'($urandom_range(0, 3));
      rq.a = rand_operand();
      rq.b = rand_operand();
      if (rq.action == rau_pkg::ACT_EQUAL && $urandom_range(0, 1)) begin
        rq.c = rq.a;
        rq.d = rq.b;
        if ($urandom_range(0, 3) == 0) rq.d[$urandom_range(0, 31)] ^= 1'b1;
      end else begin
        rq.c = rand_operand();
        rq.d = rand_operand();
      end
      pending_answers.push_back(fraction_result(rq));
      send(rq);
      burst = $urandom_range(0, 3);
      if (burst == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    drop_valid();
    stim_done = 1'b1;
  end

  // Receiver stall pattern
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        hold = 0;
        while (hold < 3000) begin
          @(negedge clk);
          hold++;
        end
        out_stall <= 1'b0;
        wait (!long_hold);
      end else if ($urandom_range(0, 15) < 4) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  // Checker and watchdog
  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result num=%h den=%h", $time, out_num, out_den);
          errors++;
        end else begin
          e = pending_answers.pop_front();
          if (out_num !== e.num) begin
            $display("%0t: out_num exp %h got %h", $time, e.num, out_num);
            errors++;
          end
          if (out_den !== e.den) begin
            $display("%0t: out_den exp %h got %h", $time, e.den, out_den);
            errors++;
          end
          if (is_equal !== e.eq) begin
            $display("%0t: is_equal exp %b got %b", $time, e.eq, is_equal);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status exp %b got %b", $time, e.st, status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && pending_answers.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_rational_arithmetic_unit OK");
    else $display("tb_rational_arithmetic_unit NOT OK");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("%0t: watchdog expired, %0d results outstanding", $time,
             pending_answers.size());
    $display("tb_rational_arithmetic_unit NOT OK");
    $finish;
  end
endmodule
